>>> rtl/touch_wheel_position_decoder_macros.svh
// ----------------------------------------------------------------------------
// Touch wheel position decoder: assertion macros
// Shared concurrent assertion forms, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef TOUCH_WHEEL_POSITION_DECODER_MACROS_SVH
`define TOUCH_WHEEL_POSITION_DECODER_MACROS_SVH

// Check a property outside reset.
`define TWPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define TWPD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/twpd_pkg.sv
// ----------------------------------------------------------------------------
// Touch wheel position decoder package
// Widths, constants, lane type and helper functions of the decoder.
// ----------------------------------------------------------------------------
package twpd_pkg;

    localparam int CNT_W     = 16;               // pad count width
    localparam int NUM_PADS  = 4;                // up, right, down, left
    localparam int PCT_W     = 7;
    localparam int QBITS     = 7;                // quotient bits, 0..99
    localparam int NUM_W     = CNT_W + QBITS;    // drop * 100
    localparam int STEP_W    = 6;
    localparam int LED_W     = 4;
    localparam int S_W       = 12;               // wheel sum before rounding
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 4;
    localparam int REG_SEL_W = $clog2(NUM_REGS);

    localparam int IN_W      = NUM_PADS * CNT_W;
    localparam int OUT_BITS  = STEP_W + LED_W + NUM_PADS * PCT_W;
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD   = OUT_W - OUT_BITS;

    // Pad lanes, also the order of the register groups
    localparam int PAD_UP    = 0;
    localparam int PAD_RIGHT = 1;
    localparam int PAD_DOWN  = 2;
    localparam int PAD_LEFT  = 3;

    localparam int REG_UNTOUCHED_BASE = 0;
    localparam int REG_SPAN_BASE      = 4;

    localparam logic [CNT_W-1:0] CFG_RESET [NUM_REGS] = '{
        CNT_W'(1655), CNT_W'(1761), CNT_W'(2400), CNT_W'(2271),
        CNT_W'(103),  CNT_W'(98),   CNT_W'(200),  CNT_W'(176)
    };

    localparam int DROP_MARGIN = 5;
    localparam int PCT_FULL    = 100;
    localparam int BASE_HI     = 2400;
    localparam int BASE_LO     = 800;
    localparam int SLOPE_SHIFT = 3;              // eight counts per percent
    localparam int ROUND_HALF  = 50;
    localparam int RECIP_W     = 13;
    localparam int RECIP_MUL   = 5243;           // ceil(2^19 / 100)
    localparam int RECIP_SHIFT = 19;

    // LED band lower edges
    localparam int LED_EDGE_2 = 5;
    localparam int LED_EDGE_3 = 8;
    localparam int LED_EDGE_4 = 11;
    localparam int LED_EDGE_5 = 17;
    localparam int LED_EDGE_6 = 22;
    localparam int LED_EDGE_7 = 25;
    localparam int LED_EDGE_8 = 27;

    // Pipeline stage numbers
    localparam int ST_DROP     = 1;
    localparam int ST_NUM      = 2;
    localparam int ST_DIV_LAST = ST_NUM + QBITS;
    localparam int ST_SUM      = ST_DIV_LAST + 1;
    localparam int ST_WHEEL    = ST_SUM + 1;
    localparam int ST_OUT      = ST_WHEEL + 1;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [CNT_W-1:0] span;
        logic [QBITS-1:0] q;
        logic             touched;
        logic             full;
    } t_lane;

    typedef logic [NUM_PADS-1:0][PCT_W-1:0] t_pcts;

    // One restoring division step at quotient bit b
    function automatic t_lane div_step(input t_lane l, input int unsigned b);
        t_lane            o;
        logic [NUM_W-1:0] trial;
        o     = l;
        trial = NUM_W'(l.span) << b;
        if (l.rem >= trial) begin
            o.rem = l.rem - trial;
            o.q   = l.q | (QBITS'(1) << b);
        end
        return o;
    endfunction

    function automatic logic [LED_W-1:0] led_band(input logic [STEP_W-1:0] s);
        logic [LED_W-1:0] b;
        priority if (s == '0)                  b = LED_W'(0);
        else if (s < STEP_W'(LED_EDGE_2))      b = LED_W'(1);
        else if (s < STEP_W'(LED_EDGE_3))      b = LED_W'(2);
        else if (s < STEP_W'(LED_EDGE_4))      b = LED_W'(3);
        else if (s < STEP_W'(LED_EDGE_5))      b = LED_W'(4);
        else if (s < STEP_W'(LED_EDGE_6))      b = LED_W'(5);
        else if (s < STEP_W'(LED_EDGE_7))      b = LED_W'(6);
        else if (s < STEP_W'(LED_EDGE_8))      b = LED_W'(7);
        else                                   b = LED_W'(8);
        return b;
    endfunction

endpackage

>>> rtl/touch_wheel_position_decoder.sv
// Throughput: one item per cycle while i_m_axis_tready does not stall the
// pipeline; each pad has its own seven-stage restoring divider (one quotient
// bit per stage) and every stage holds its own valid bit.
// Each stage moves on when it is empty or its successor moves, so bubbles close up.
// Reset (synchronous, active low): the pipeline empties and the eight
// configuration registers return to their default levels and spans.
// ----------------------------------------------------------------------------
// Touch wheel position decoder
// Turns four capacitive pad counts into touch percentages, a wheel step and
// an LED band, in a twelve-stage pipeline.
// ----------------------------------------------------------------------------
module touch_wheel_position_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [twpd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [twpd_pkg::CNT_W-1:0]          i_cfg_data,
    // Input items
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata, low bit up: raw_up, raw_right, raw_down, raw_left
    input  logic [twpd_pkg::IN_W-1:0]           i_s_axis_tdata,
    // Result items
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata, low bit up: wheel_step, led_index, pct_up, pct_right, pct_down,
    // pct_left, zero fill
    output logic [twpd_pkg::OUT_W-1:0]          o_m_axis_tdata
);
    import twpd_pkg::*;

    // Configuration registers: idle levels then spans, in pad order
    logic [CNT_W-1:0] r_cfg [NUM_REGS];

    // Stage valid bits and advance enables
    logic [ST_OUT:1] r_v;
    logic [ST_OUT:1] n_v;
    logic [ST_OUT:1] stg_en;

    // Per-pad lanes from the drop stage to the last division step
    t_lane r_ln [ST_DROP:ST_DIV_LAST][NUM_PADS];
    t_lane n_ln [ST_DROP:ST_DIV_LAST][NUM_PADS];

    // Tail stages
    t_pcts              r_pct_sum, n_pct_sum;
    logic [S_W-1:0]     r_x, n_x;
    t_pcts              r_pct_wh;
    logic [STEP_W-1:0]  r_wheel, n_wheel;
    t_pcts              r_pct_out;
    logic [STEP_W-1:0]  r_step_out;
    logic [LED_W-1:0]   r_led_out, n_led_out;

    logic [S_W+RECIP_W-1:0] prod;

    // ------------------------------------------------------------------
    // Configuration: always ready, writes past the list are dropped
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(NUM_REGS))) begin
            r_cfg[i_cfg_index[REG_SEL_W-1:0]] <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Flow control: a stage advances when empty or when the next one does
    // ------------------------------------------------------------------
    always_comb begin
        stg_en[ST_OUT] = !r_v[ST_OUT] || i_m_axis_tready;
        for (int k = ST_OUT - 1; k >= 1; k--) begin
            stg_en[k] = !r_v[k] || stg_en[k+1];
        end
        n_v[1] = i_s_axis_tvalid;
        for (int k = 2; k <= ST_OUT; k++) begin
            n_v[k] = r_v[k-1];
        end
    end

    assign o_s_axis_tready = stg_en[1];
    assign o_m_axis_tvalid = r_v[ST_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 1; k <= ST_OUT; k++) begin
                if (stg_en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Lane stages: drop, numerator, then one quotient bit per stage
    // ------------------------------------------------------------------
    always_comb begin
        for (int p = 0; p < NUM_PADS; p++) begin
            logic [CNT_W-1:0] raw;
            logic [CNT_W-1:0] idle;
            raw  = i_s_axis_tdata[p*CNT_W +: CNT_W];
            idle = r_cfg[REG_UNTOUCHED_BASE + p];
            // Drop only counts when raw + margin stays below idle, no wrap
            n_ln[ST_DROP][p].touched = ({1'b0, raw} + (CNT_W+1)'(DROP_MARGIN))
                                       < {1'b0, idle};
            n_ln[ST_DROP][p].rem     = NUM_W'(idle - raw);
            n_ln[ST_DROP][p].span    = r_cfg[REG_SPAN_BASE + p];
            n_ln[ST_DROP][p].q       = '0;
            n_ln[ST_DROP][p].full    = 1'b0;

            // Scale drop by 100; a drop at or past the span saturates
            n_ln[ST_NUM][p]      = r_ln[ST_DROP][p];
            n_ln[ST_NUM][p].rem  = NUM_W'(r_ln[ST_DROP][p].rem[CNT_W-1:0])
                                   * NUM_W'(PCT_FULL);
            n_ln[ST_NUM][p].full = r_ln[ST_DROP][p].touched &&
                                   (r_ln[ST_DROP][p].rem[CNT_W-1:0]
                                    >= r_ln[ST_DROP][p].span);

            for (int k = ST_NUM + 1; k <= ST_DIV_LAST; k++) begin
                n_ln[k][p] = div_step(r_ln[k-1][p], ST_DIV_LAST - k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = ST_DROP; k <= ST_DIV_LAST; k++) begin
            if (stg_en[k]) begin
                r_ln[k] <= n_ln[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Sum stage: pick percentages, sign up/down by left against right
    // ------------------------------------------------------------------
    always_comb begin
        logic [S_W-1:0] slope_u;
        logic [S_W-1:0] slope_d;
        for (int p = 0; p < NUM_PADS; p++) begin
            priority if (r_ln[ST_DIV_LAST][p].full) begin
                n_pct_sum[p] = PCT_W'(PCT_FULL);
            end else if (r_ln[ST_DIV_LAST][p].touched) begin
                n_pct_sum[p] = r_ln[ST_DIV_LAST][p].q;
            end else begin
                n_pct_sum[p] = '0;
            end
        end
        slope_u = S_W'(n_pct_sum[PAD_UP]) << SLOPE_SHIFT;
        slope_d = S_W'(n_pct_sum[PAD_DOWN]) << SLOPE_SHIFT;
        // Rounding half is folded in here ahead of the divide by 100
        priority if (n_pct_sum[PAD_UP] != '0) begin
            if (n_pct_sum[PAD_LEFT] > n_pct_sum[PAD_RIGHT]) begin
                n_x = S_W'(BASE_HI + ROUND_HALF) + slope_u;
            end else begin
                n_x = S_W'(BASE_LO + ROUND_HALF) - slope_u;
            end
        end else if (n_pct_sum[PAD_DOWN] != '0) begin
            if (n_pct_sum[PAD_RIGHT] > n_pct_sum[PAD_LEFT]) begin
                n_x = S_W'(BASE_LO + ROUND_HALF) + slope_d;
            end else begin
                n_x = S_W'(BASE_HI + ROUND_HALF) - slope_d;
            end
        end else begin
            n_x = S_W'(ROUND_HALF);
        end
    end

    // Divide by 100 through a reciprocal; exact over the sum's range
    assign prod      = (S_W+RECIP_W)'(r_x) * (S_W+RECIP_W)'(RECIP_MUL);
    assign n_wheel   = prod[RECIP_SHIFT +: STEP_W];
    assign n_led_out = led_band(r_wheel);

    always_ff @(posedge i_clk) begin
        if (stg_en[ST_SUM]) begin
            r_pct_sum <= n_pct_sum;
            r_x       <= n_x;
        end
        if (stg_en[ST_WHEEL]) begin
            r_pct_wh <= r_pct_sum;
            r_wheel  <= n_wheel;
        end
        if (stg_en[ST_OUT]) begin
            r_pct_out  <= r_pct_wh;
            r_step_out <= r_wheel;
            r_led_out  <= n_led_out;
        end
    end

    assign o_m_axis_tdata = {{OUT_PAD{1'b0}},
                             r_pct_out[PAD_LEFT], r_pct_out[PAD_DOWN],
                             r_pct_out[PAD_RIGHT], r_pct_out[PAD_UP],
                             r_led_out, r_step_out};

endmodule

>>> rtl/twpd_checker.sv
// ----------------------------------------------------------------------------
// Touch wheel position decoder checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "touch_wheel_position_decoder_macros.svh"

module twpd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic [twpd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [twpd_pkg::CNT_W-1:0]     i_cfg_data,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic [twpd_pkg::IN_W-1:0]      i_s_axis_tdata,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [twpd_pkg::OUT_W-1:0]     o_m_axis_tdata
);

    // Hold a stalled item
    `TWPD_ASSERT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed")

    // Drop any result after reset
    `TWPD_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_m_axis_tvalid, "result valid after reset")

    // Step stays on the wheel and lights LEDs exactly when non-zero
    `TWPD_ASSERT(a_step_led, o_m_axis_tvalid |-> (o_m_axis_tdata[5:0] <= 6'd32) && ((o_m_axis_tdata[5:0] == 6'd0) == (o_m_axis_tdata[9:6] == 4'd0)), "wheel step and LED band disagree")

    // Percentages saturate at full touch
    `TWPD_ASSERT(a_pct_range, o_m_axis_tvalid |-> (o_m_axis_tdata[16:10] <= 7'd100) && (o_m_axis_tdata[23:17] <= 7'd100) && (o_m_axis_tdata[30:24] <= 7'd100) && (o_m_axis_tdata[37:31] <= 7'd100), "percentage above 100")

endmodule

bind touch_wheel_position_decoder twpd_checker u_twpd_checker (.*);
